@@ sv/oust_pkg.sv @@
// package for the ordered unique set table
// holds item structs, command codes, cell control and state types
// no dependencies
package oust_pkg;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] value;
        logic [3:0]  position;
    } in_item_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic        already_present;
        logic        accepted;
        logic [4:0]  element_count;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

@@ sv/oust_cell.sv @@
// one storage cell of the ordered unique set table
// holds one element, compares it with the key, takes its upper neighbor on shift
// depends on oust_pkg
module oust_cell #(
    parameter int W = 32
) (
    input  logic              clk,
    input  oust_pkg::cell_ctl_t ctl,
    input  logic [W-1:0]      key,
    input  logic              in_use,
    input  logic [W-1:0]      neighbor,
    output logic [W-1:0]      elem,
    output logic              hit
);
    import oust_pkg::*;

    logic [W-1:0] elem_reg;
    logic [W-1:0] elem_next;

    always_comb
    begin
        elem_next = elem_reg;
        priority if (ctl.load)
        begin
            elem_next = key;
        end
        else if (ctl.shift)
        begin
            elem_next = neighbor;
        end
    end

    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
    end

    assign elem = elem_reg;
    assign hit  = in_use && (elem_reg == key);

endmodule

@@ sv/ordered_unique_set_table_unit.sv @@
// top level of the ordered unique set table
// control, element count and result register around a chain of oust_cell
// depends on oust_pkg and oust_cell
//
//  channel | signals                      | direction | payload
//  --------+------------------------------+-----------+------------------
//  command | cmd_valid cmd_ready cmd_item | in        | oust_pkg::in_item_t
//  result  | rsp_valid rsp_ready rsp_item | out       | oust_pkg::out_item_t
//
// an item is captured in the idle state; in the execute state every cell compares
// in parallel and the chain appends, shifts down or is read
// a new item is taken while a result still waits in the output register
// the execute cycle stalls while that register holds an untaken result
// reset clears the count, control and output valid; cell contents need no reset
module ordered_unique_set_table_unit #(
    parameter int CAPACITY      = 16,
    parameter int ELEMENT_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  oust_pkg::in_item_t  cmd_item,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output oust_pkg::out_item_t rsp_item
);
    import oust_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;
    localparam int RDN  = (CAPACITY < 16) ? CAPACITY : 16;

    state_t    state_reg, state_next;
    in_item_t  item_reg, item_next;
    out_item_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;
    logic [CW-1:0] count_reg, count_next;

    logic [ELEMENT_WIDTH-1:0] key;
    logic [ELEMENT_WIDTH-1:0] elems [CAPACITY];
    logic [CAPACITY-1:0]      hits;
    logic [CAPACITY-1:0]      loads;
    cell_ctl_t                ctls [CAPACITY];

    logic go;
    logic found;
    logic full;
    logic pos_ok;
    logic do_add;
    logic do_remove;
    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] count_ext;
    logic [ELEMENT_WIDTH-1:0] rd_elem;
    logic [63:0] rd_wide;
    logic [15:0] cnt_wide;

    assign key       = ELEMENT_WIDTH'(item_reg.value);
    assign found     = |hits;
    assign full      = (count_reg == CW'(CAPACITY));
    assign pos_ext   = CMPW'(item_reg.position);
    assign count_ext = CMPW'(count_reg);
    assign pos_ok    = (pos_ext < count_ext);
    assign do_add    = go && (item_reg.cmd == CMD_ADD) && !found && !full;
    assign do_remove = go && (item_reg.cmd == CMD_REMOVE) && pos_ok;

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic [ELEMENT_WIDTH-1:0] up;

        if (k + 1 < CAPACITY)
        begin : g_mid
            assign up = elems[k+1];
        end
        else
        begin : g_end
            assign up = '0;
        end

        assign ctls[k].load  = do_add && (count_reg == CW'(k));
        assign ctls[k].shift = do_remove && (CMPW'(k) >= pos_ext)
                               && (CMPW'(k + 1) < count_ext);
        assign loads[k]      = ctls[k].load;

        oust_cell #(
            .W (ELEMENT_WIDTH)
        ) u_cell (
            .clk      (clk),
            .ctl      (ctls[k]),
            .key      (key),
            .in_use   (CW'(k) < count_reg),
            .neighbor (up),
            .elem     (elems[k]),
            .hit      (hits[k])
        );
    end

    always_comb
    begin
        rd_elem = '0;
        for (int k = 0; k < RDN; k++)
        begin
            if (item_reg.position == 4'(k))
            begin
                rd_elem = elems[k];
            end
        end
    end

    assign rd_wide = 64'(rd_elem);

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        count_next     = count_reg;
        go             = 1'b0;
        cnt_wide       = '0;
        cmd_ready      = (state_reg == ST_IDLE);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    item_next  = cmd_item;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    go = 1'b1;
                    out_next.read_value      = '0;
                    out_next.already_present = 1'b0;
                    out_next.accepted        = 1'b0;
                    unique case (item_reg.cmd)
                        CMD_ADD:
                        begin
                            out_next.already_present = found;
                            if (!found && !full)
                            begin
                                out_next.accepted = 1'b1;
                                count_next        = count_reg + 1'b1;
                            end
                        end
                        CMD_READ:
                        begin
                            if (pos_ok)
                            begin
                                out_next.accepted   = 1'b1;
                                out_next.read_value = rd_wide[31:0];
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (pos_ok)
                            begin
                                out_next.accepted = 1'b1;
                                count_next        = count_reg - 1'b1;
                            end
                        end
                        default:
                        begin
                            out_next.accepted = 1'b0;
                        end
                    endcase
                    cnt_wide               = 16'(count_next);
                    out_next.element_count = cnt_wide[4:0];
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        out_reg  <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_item  = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(loads))
        else $error("more than one cell loaded");

    a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_add |=> count_reg == $past(count_reg) + 1'b1)
        else $error("add did not grow the table");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.already_present && out_reg.accepted))
        else $error("duplicate add reported as accepted");

    a_take_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> state_reg == ST_EXEC)
        else $error("taken item not executed");

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// testbench for ordered_unique_set_table_unit: directed and random add, read, remove items
// a tracker class predicts each result and checks every returned item
// depends on oust_pkg and ordered_unique_set_table_unit
class oust_tracker;

    localparam int CAPACITY = 16;

    logic [31:0]         stored [CAPACITY];
    int                  fill_count;
    oust_pkg::out_item_t expected_rsp [$];
    int                  error_count;

    function new();
        fill_count  = 0;
        error_count = 0;
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    function void note_command(oust_pkg::in_item_t item);
        oust_pkg::out_item_t rsp;
        bit                  hit;
        rsp = '0;
        hit = 1'b0;
        case (item.cmd)
            oust_pkg::CMD_ADD:
            begin
                for (int k = 0; k < fill_count; k++)
                begin
                    if (stored[k] == item.value)
                        hit = 1'b1;
                end
                if (hit)
                    rsp.already_present = 1'b1;
                else if (fill_count < CAPACITY)
                begin
                    stored[fill_count] = item.value;
                    fill_count++;
                    rsp.accepted = 1'b1;
                end
            end
            oust_pkg::CMD_READ:
            begin
                if (int'(item.position) < fill_count)
                begin
                    rsp.read_value = stored[item.position];
                    rsp.accepted   = 1'b1;
                end
            end
            oust_pkg::CMD_REMOVE:
            begin
                if (int'(item.position) < fill_count)
                begin
                    for (int k = item.position; k + 1 < fill_count; k++)
                        stored[k] = stored[k + 1];
                    fill_count--;
                    rsp.accepted = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        rsp.element_count = fill_count[4:0];
        expected_rsp.push_back(rsp);
    endfunction

    task check_result(oust_pkg::out_item_t got);
        oust_pkg::out_item_t want;
        if (expected_rsp.size() == 0)
        begin
            report_mismatch("unexpected item", got.read_value, 32'd0);
            return;
        end
        want = expected_rsp.pop_front();
        if (got.read_value !== want.read_value)
            report_mismatch("read_value", got.read_value, want.read_value);
        if (got.already_present !== want.already_present)
            report_mismatch("already_present", 32'(got.already_present),
                            32'(want.already_present));
        if (got.accepted !== want.accepted)
            report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
        if (got.element_count !== want.element_count)
            report_mismatch("element_count", 32'(got.element_count),
                            32'(want.element_count));
    endtask

endclass

module tb_top;

    import oust_pkg::*;

    localparam logic [1:0] CMD_NONE    = 2'd3;
    localparam int         RANDOM_CMDS = 1300;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         POOL_SIZE   = 24;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_ready;
    in_item_t    cmd_item;
    logic        rsp_valid;
    logic        rsp_ready;
    out_item_t   rsp_item;

    oust_tracker sb = new();
    int          cycle_count = 0;
    int          burst_left  = 0;
    logic [31:0] value_pool [POOL_SIZE];

    ordered_unique_set_table_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_item  (rsp_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            sb.check_result(rsp_item);
    end

    function automatic in_item_t make_item(logic [1:0] cmd, logic [31:0] value,
                                           logic [3:0] position);
        in_item_t item;
        item.cmd      = cmd;
        item.value    = value;
        item.position = position;
        return item;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_command(in_item_t item);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
            begin
                cmd_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        cmd_item  <= item;
        cmd_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cmd_ready);
        sb.note_command(item);
        @(negedge clk);
    endtask

    function automatic in_item_t random_command(int bias);
        int          pick;
        logic [1:0]  cmd;
        logic [31:0] value;
        logic [3:0]  position;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            cmd = CMD_NONE;
        else if (pick < (bias == 0 ? 63 : bias == 1 ? 25 : 42))
            cmd = CMD_ADD;
        else if (pick < (bias == 0 ? 80 : bias == 1 ? 45 : 70))
            cmd = CMD_READ;
        else
            cmd = CMD_REMOVE;
        if ($urandom_range(0, 9) < 6)
            value = value_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            value = $urandom;
        if (sb.fill_count > 0 && $urandom_range(0, 3) != 0)
            position = 4'($urandom_range(0, sb.fill_count - 1));
        else
            position = 4'($urandom_range(0, 15));
        return make_item(cmd, value, position);
    endfunction

    initial
    begin
        int mode_left;
        int bias;
        rsp_ready = 1'b0;
        forever
        begin
            mode_left = $urandom_range(10, 150);
            bias      = $urandom_range(0, 2);
            repeat (mode_left)
            begin
                @(negedge clk);
                case (bias)
                    0: rsp_ready <= 1'b1;
                    1: rsp_ready <= 1'($urandom_range(0, 1));
                    default: rsp_ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    initial
    begin
        in_item_t directed [$];
        int       mode_left;
        int       bias;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd_item  = '0;
        for (int k = 0; k < POOL_SIZE; k++)
            value_pool[k] = $urandom;
        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table, unused code, extreme values and a duplicate
        directed.push_back(make_item(CMD_READ, 32'hFFFF_FFFF, 4'd0));
        directed.push_back(make_item(CMD_REMOVE, 32'h0, 4'd15));
        directed.push_back(make_item(CMD_NONE, 32'hFFFF_FFFF, 4'd15));
        directed.push_back(make_item(CMD_ADD, 32'h0000_0000, 4'd0));
        directed.push_back(make_item(CMD_ADD, 32'hFFFF_FFFF, 4'd15));
        directed.push_back(make_item(CMD_ADD, 32'h0000_0000, 4'd7));
        // fill, then add to a full table
        for (int k = 0; k < 14; k++)
            directed.push_back(make_item(CMD_ADD, 32'h1 << k, 4'(k)));
        directed.push_back(make_item(CMD_ADD, 32'hA5A5_5A5A, 4'd0));
        directed.push_back(make_item(CMD_ADD, 32'hFFFF_FFFF, 4'd0));
        directed.push_back(make_item(CMD_READ, 32'h0, 4'd15));
        directed.push_back(make_item(CMD_REMOVE, 32'h0, 4'd0));
        directed.push_back(make_item(CMD_REMOVE, 32'h0, 4'd15));
        directed.push_back(make_item(CMD_READ, 32'h0, 4'd0));
        foreach (directed[i])
            send_command(directed[i]);

        mode_left = 0;
        bias      = 2;
        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (mode_left == 0)
            begin
                mode_left = $urandom_range(20, 80);
                bias      = $urandom_range(0, 2);
            end
            mode_left--;
            send_command(random_command(bias));
        end
        cmd_valid <= 1'b0;

        while (sb.expected_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.expected_rsp.size() != 0)
            sb.report_mismatch("missing item", 32'd0, sb.expected_rsp.size());
        if (sb.error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ files.f @@
sv/oust_pkg.sv
sv/oust_cell.sv
sv/ordered_unique_set_table_unit.sv
verif/tb_top.sv
